[sv/vm16_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vm16 package
// shared constants, opcodes and status codes of the 16-bit machine
// ----------------------------------------------------------------------------
package vm16_pkg;

  localparam int MEM_WORDS = 256;
  localparam int AW        = $clog2(MEM_WORDS);

  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_START  = 2'd1;
  localparam logic [1:0] CMD_EXEC   = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_HALT    = 3'd1;
  localparam logic [2:0] ST_LIMIT   = 3'd2;
  localparam logic [2:0] ST_OVF     = 3'd3;
  localparam logic [2:0] ST_UNF     = 3'd4;
  localparam logic [2:0] ST_BADOP   = 3'd5;
  localparam logic [2:0] ST_STOPPED = 3'd6;

  localparam logic [4:0] OP_LOAD  = 5'd0;
  localparam logic [4:0] OP_STORE = 5'd1;
  localparam logic [4:0] OP_ADD   = 5'd2;
  localparam logic [4:0] OP_ADDC  = 5'd3;
  localparam logic [4:0] OP_SUB   = 5'd4;
  localparam logic [4:0] OP_SUBC  = 5'd5;
  localparam logic [4:0] OP_AND   = 5'd6;
  localparam logic [4:0] OP_XOR   = 5'd7;
  localparam logic [4:0] OP_NOT   = 5'd8;
  localparam logic [4:0] OP_SHL   = 5'd9;
  localparam logic [4:0] OP_SAL   = 5'd10;
  localparam logic [4:0] OP_SHR   = 5'd11;
  localparam logic [4:0] OP_SAR   = 5'd12;
  localparam logic [4:0] OP_CMP   = 5'd13;
  localparam logic [4:0] OP_GETST = 5'd14;
  localparam logic [4:0] OP_PUTST = 5'd15;
  localparam logic [4:0] OP_JMP   = 5'd16;
  localparam logic [4:0] OP_JLT   = 5'd17;
  localparam logic [4:0] OP_JEQ   = 5'd18;
  localparam logic [4:0] OP_JGT   = 5'd19;
  localparam logic [4:0] OP_CALL  = 5'd20;
  localparam logic [4:0] OP_RET   = 5'd21;
  localparam logic [4:0] OP_READ  = 5'd22;
  localparam logic [4:0] OP_WRITE = 5'd23;
  localparam logic [4:0] OP_HALT  = 5'd24;
  localparam logic [4:0] OP_NOOP  = 5'd25;

  localparam int FRAME = 6;

  // one memory access request from the sequencer
  typedef struct packed {
    logic          en;
    logic          we;
    logic [AW-1:0] addr;
    logic [15:0]   wdata;
  } mem_req_t;

endpackage

[sv/vm16_instruction_executor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vm16 instruction executor
// 16-bit four-register machine with single-port memory
// ----------------------------------------------------------------------------
// Requests arrive on the in_ channel: load a memory word, restart the run
// state, or execute one instruction. Each request gives exactly one result
// on the out_ channel. cfg_ writes program_limit; the user must do so only
// while the block is idle, as the block itself does not enforce it. One
// request is worked at a time; the memory port sets the time. Steps:
//   load, start, refused execute: straight to the result
//   plain instruction and store: fetch, decode and execute
//   data load: fetch, execute, data read
//   call and return: fetch, execute, six stack words, one a cycle
// in_tready comes back together with out_tvalid when the receiver is ready.
// in_tready is high only while no request is in work and the result
// register is free or being taken in the same cycle; a stalled receiver
// holds the result and blocks the next request.
// Reset (rst_n low, synchronous) clears registers, pc, cost and limit, sets
// the stack pointer to 256 and flags to 2; memory is undefined until loaded.
// ----------------------------------------------------------------------------
module vm16_instruction_executor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // cmd
  input  logic [39:0] in_tdata,   // load_index[7:0], load_word[23:8], read_value[39:24]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // status[2:0], write_valid[3], write_value[19:4],
                                  // program_counter[28:20], status_flags[33:29],
                                  // cycle_count[65:34], zero[71:66]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_data
);
  import vm16_pkg::*;

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FETCH = 4'd1;
  localparam logic [3:0] S_EXEC  = 4'd2;
  localparam logic [3:0] S_LDW   = 4'd3;
  localparam logic [3:0] S_PUSH  = 4'd4;
  localparam logic [3:0] S_POP   = 4'd5;
  localparam logic [3:0] S_DONE  = 4'd6;

  logic [3:0]  state_r, state_nxt;
  logic [15:0] regs_r [4];
  logic [15:0] regs_nxt [4];
  logic [8:0]  pc_r, pc_nxt, sp_r, sp_nxt, limit_r;
  logic [4:0]  flags_r, flags_nxt;
  logic [31:0] cost_r, cost_nxt;
  logic        stop_r, stop_nxt;
  logic [15:0] ir_r, ir_nxt, rv_r;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [2:0]  st_r, st_nxt;
  logic        wv_r, wv_nxt;
  logic [15:0] wval_r, wval_nxt;
  logic        ov_r;
  logic [2:0]  o_st_r;
  logic        o_wv_r;
  logic [15:0] o_wval_r;
  logic [8:0]  o_pc_r;
  logic [4:0]  o_fl_r;
  logic [31:0] o_cost_r;
  mem_req_t    req;
  logic [15:0] rdata;
  logic        in_acc;

  vm16_ram u_ram (.clk(clk), .req(req), .rdata(rdata));

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == S_IDLE) && (!ov_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;
  assign out_tvalid = ov_r;
  assign out_tdata = {6'd0, o_cost_r, o_fl_r, o_pc_r, o_wval_r, o_wv_r, o_st_r};

  // decode fields of the instruction
  logic [4:0]  op;
  logic [1:0]  rd, rs;
  logic        imm;
  logic [7:0]  addr;
  logic [16:0] a, b, res, cst;
  assign op   = ir_r[15:11];
  assign rd   = ir_r[10:9];
  assign imm  = ir_r[8];
  assign rs   = ir_r[7:6];
  assign addr = ir_r[7:0];
  assign cst  = {{9{addr[7]}}, addr};
  assign a    = {regs_r[rd][15], regs_r[rd]};
  assign b    = imm ? cst : {regs_r[rs][15], regs_r[rs]};

  always_comb begin
    state_nxt = state_r;
    for (int i = 0; i < 4; i++) regs_nxt[i] = regs_r[i];
    pc_nxt = pc_r; sp_nxt = sp_r; flags_nxt = flags_r; cost_nxt = cost_r;
    stop_nxt = stop_r; ir_nxt = ir_r; cnt_nxt = cnt_r;
    st_nxt = st_r; wv_nxt = wv_r; wval_nxt = wval_r;
    req = '0; res = '0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          st_nxt = ST_OK; wv_nxt = 1'b0; wval_nxt = '0;
          state_nxt = S_DONE;
          case (in_tuser)
            CMD_LOAD: begin
              req.en = 1'b1; req.we = 1'b1;
              req.addr = in_tdata[AW-1:0]; req.wdata = in_tdata[23:8];
            end
            CMD_START: begin
              pc_nxt = '0; sp_nxt = 9'(MEM_WORDS); flags_nxt = 5'd2; stop_nxt = 1'b0;
            end
            CMD_EXEC: begin
              if (stop_r) st_nxt = ST_STOPPED;
              else if (pc_r >= limit_r) st_nxt = ST_LIMIT;
              else begin
                req.en = 1'b1; req.addr = pc_r[AW-1:0];
                pc_nxt = pc_r + 9'd1; cost_nxt = cost_r + 32'd1;
                state_nxt = S_FETCH;
              end
            end
            default: ;
          endcase
        end
      end
      S_FETCH: begin
        ir_nxt = rdata;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_DONE;
        case (op)
          OP_LOAD: begin
            if (imm) regs_nxt[rd] = cst[15:0];
            else begin
              req.en = 1'b1; req.addr = addr[AW-1:0];
              cost_nxt = cost_r + 32'd3; state_nxt = S_LDW;
            end
          end
          OP_STORE: begin
            req.en = 1'b1; req.we = 1'b1; req.addr = addr[AW-1:0];
            req.wdata = regs_r[rd]; cost_nxt = cost_r + 32'd3;
          end
          OP_ADD, OP_SUB: begin
            res = (op == OP_ADD) ? a + b : a - b;
            flags_nxt[0] = res[16];
            flags_nxt[4] = (a[15] == b[15]) && (a[15] != res[15]);
            regs_nxt[rd] = res[15:0];
          end
          OP_ADDC, OP_SUBC: begin
            res = (op == OP_ADDC) ? a + b + {16'd0, flags_r[0]}
                                  : a - b - {16'd0, flags_r[0]};
            flags_nxt[0] = res[16];
            regs_nxt[rd] = res[15:0];
          end
          OP_AND: regs_nxt[rd] = a[15:0] & b[15:0];
          OP_XOR: regs_nxt[rd] = a[15:0] ^ b[15:0];
          OP_NOT: regs_nxt[rd] = ~a[15:0];
          OP_SHL: begin
            flags_nxt[0] = a[15]; regs_nxt[rd] = {a[14:0], 1'b0};
          end
          OP_SAL: begin
            flags_nxt[0] = a[15]; regs_nxt[rd] = {a[15], a[13:0], 1'b0};
          end
          OP_SHR, OP_SAR: begin
            flags_nxt[0] = a[0];
            regs_nxt[rd] = {(op == OP_SAR) & a[15], a[15:1]};
          end
          OP_CMP: begin
            flags_nxt = flags_r & 5'd17;
            if ($signed(a) < $signed(b)) flags_nxt[3] = 1'b1;
            else if (a != b) flags_nxt[1] = 1'b1;
            else flags_nxt[2] = 1'b1;
          end
          OP_GETST: regs_nxt[rd] = {11'd0, flags_r};
          OP_PUTST: flags_nxt = regs_r[rd][4:0];
          OP_JMP: pc_nxt = {1'b0, addr};
          OP_JLT: if (flags_r[3]) pc_nxt = {1'b0, addr};
          OP_JEQ: if (flags_r[2]) pc_nxt = {1'b0, addr};
          OP_JGT: if (flags_r[1]) pc_nxt = {1'b0, addr};
          OP_CALL: begin
            if ({1'b0, sp_r} < {1'b0, limit_r} + 10'(FRAME)) begin
              stop_nxt = 1'b1; st_nxt = ST_OVF;
            end else begin
              cnt_nxt = '0; state_nxt = S_PUSH;
            end
          end
          OP_RET: begin
            if (sp_r > 9'(MEM_WORDS - FRAME)) begin
              stop_nxt = 1'b1; st_nxt = ST_UNF;
            end else begin
              req.en = 1'b1; req.addr = sp_r[AW-1:0];
              cnt_nxt = '0; state_nxt = S_POP;
            end
          end
          OP_READ: begin
            regs_nxt[rd] = rv_r; cost_nxt = cost_r + 32'd27;
          end
          OP_WRITE: begin
            wv_nxt = 1'b1; wval_nxt = regs_r[rd]; cost_nxt = cost_r + 32'd27;
          end
          OP_HALT: begin
            stop_nxt = 1'b1; st_nxt = ST_HALT;
          end
          OP_NOOP: ;
          default: begin
            stop_nxt = 1'b1; st_nxt = ST_BADOP;
          end
        endcase
      end
      S_LDW: begin
        regs_nxt[rd] = rdata;
        state_nxt = S_DONE;
      end
      // push pc, r3, r2, r1, r0, flags one word a cycle
      S_PUSH: begin
        req.en = 1'b1; req.we = 1'b1;
        req.addr = AW'(sp_r - 9'd1);
        sp_nxt = sp_r - 9'd1;
        case (cnt_r)
          3'd0: req.wdata = {7'd0, pc_r};
          3'd1: req.wdata = regs_r[3];
          3'd2: req.wdata = regs_r[2];
          3'd3: req.wdata = regs_r[1];
          3'd4: req.wdata = regs_r[0];
          default: req.wdata = {11'd0, flags_r};
        endcase
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'(FRAME - 1)) begin
          pc_nxt = {1'b0, addr}; cost_nxt = cost_r + 32'd3;
          state_nxt = S_DONE;
        end
      end
      // pop: each read is issued in the cycle before its capture
      S_POP: begin
        if (cnt_r != 3'(FRAME - 1)) begin
          req.en = 1'b1; req.addr = AW'(sp_r + 9'(cnt_r) + 9'd1);
        end
        case (cnt_r)
          3'd0: flags_nxt = rdata[4:0];
          3'd1: regs_nxt[0] = rdata;
          3'd2: regs_nxt[1] = rdata;
          3'd3: regs_nxt[2] = rdata;
          3'd4: regs_nxt[3] = rdata;
          default: pc_nxt = rdata[8:0];
        endcase
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'(FRAME - 1)) begin
          sp_nxt = sp_r + 9'(FRAME); cost_nxt = cost_r + 32'd3;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      for (int i = 0; i < 4; i++) regs_r[i] <= '0;
      pc_r <= '0; sp_r <= 9'(MEM_WORDS); flags_r <= 5'd2; cost_r <= '0;
      stop_r <= 1'b0; limit_r <= '0; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      for (int i = 0; i < 4; i++) regs_r[i] <= regs_nxt[i];
      pc_r <= pc_nxt; sp_r <= sp_nxt; flags_r <= flags_nxt; cost_r <= cost_nxt;
      stop_r <= stop_nxt;
      if (cfg_valid) limit_r <= (cfg_data > 9'd256) ? 9'd256 : cfg_data;
      if (state_r == S_DONE) ov_r <= 1'b1;
      else if (out_tready) ov_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ir_r <= ir_nxt; cnt_r <= cnt_nxt; st_r <= st_nxt;
    wv_r <= wv_nxt; wval_r <= wval_nxt;
    if (in_acc) rv_r <= in_tdata[39:24];
    if (state_r == S_DONE) begin
      o_st_r <= st_r; o_wv_r <= wv_r; o_wval_r <= wval_r;
      o_pc_r <= pc_r; o_fl_r <= flags_r; o_cost_r <= cost_r;
    end
  end

endmodule

[sv/vm16_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vm16 ram
// single-port program, data and stack memory with registered read
// ----------------------------------------------------------------------------
module vm16_ram (
  input  logic              clk,
  input  vm16_pkg::mem_req_t req,
  output logic [15:0]       rdata
);
  import vm16_pkg::*;

  logic [15:0] mem [MEM_WORDS];

  // one access a cycle, read data valid next cycle
  always_ff @(posedge clk) begin
    if (req.en) begin
      if (req.we) begin
        mem[req.addr] <= req.wdata;
      end else begin
        rdata <= mem[req.addr];
      end
    end
  end

endmodule

[sv/vm16_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vm16 checker
// port-level checks of the executor, bound to the top level
// ----------------------------------------------------------------------------
module vm16_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // no new request while a result is stalled
  a_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("request taken over a stalled result");

  // in_tready is low in the cycle after a request is accepted
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("ready during work");

  // status code stays within its range
  a_st: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2:0] != 3'd7)
    else $error("bad status code");

endmodule

bind vm16_instruction_executor vm16_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
